// ----- src/ddcpd_pkg.sv -----
// Package for the differential-drive cascaded PD controller.
// Holds Q16.16 constants, register reset values, sequencer codes and helpers.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ddcpd_pkg;

  localparam int unsigned CountsPerRevDefault = 3200;

  // Fixed constants, Q16.16 except MS_PER_S, PWM_LIMIT and PWM_FIXED, which are plain integers.
  localparam logic signed [31:0] TWO_PI_Q       = 32'sd411775;
  localparam logic signed [31:0] K_RHO_Q        = 32'sd2392;
  localparam logic signed [31:0] K_PHI_Q        = 32'sd19567;
  localparam logic signed [31:0] PWM_PER_VOLT_Q = 32'sd2387476;
  localparam logic signed [31:0] DEADBAND_Q     = 32'sd3277;
  localparam logic signed [31:0] MS_PER_S       = 32'sd1000;
  localparam logic [7:0]         PWM_LIMIT      = 8'd255;
  localparam logic [6:0]         PWM_FIXED      = 7'd40;

  // Register reset values.
  localparam logic [30:0]        KP_DIST_RST = 31'd228858;
  localparam logic [30:0]        KD_DIST_RST = 31'd123316;
  localparam logic [30:0]        KP_HEAD_RST = 31'd1060393;
  localparam logic [30:0]        KD_HEAD_RST = 31'd172719;
  localparam logic [30:0]        KP_FR_RST   = 31'd1110180;
  localparam logic [30:0]        KP_TR_RST   = 31'd276754;
  localparam logic signed [31:0] TGT_DIST_RST = 32'sd0;
  localparam logic signed [31:0] TGT_HEAD_RST = 32'sd102944;

  // Datapath widths.
  localparam int unsigned MA_W  = 34;
  localparam int unsigned MB_W  = 32;
  localparam int unsigned P_W   = MA_W + MB_W;
  localparam int unsigned DIV_W = 51;
  localparam int unsigned DCNT_W = $clog2(DIV_W);

  typedef enum logic [2:0] {
    REG_KP_DIST  = 3'd0,
    REG_KD_DIST  = 3'd1,
    REG_KP_HEAD  = 3'd2,
    REG_KD_HEAD  = 3'd3,
    REG_KP_FR    = 3'd4,
    REG_KP_TR    = 3'd5,
    REG_TGT_DIST = 3'd6,
    REG_TGT_HEAD = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DSET,
    ST_DIV,
    ST_POST,
    ST_WB,
    ST_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_ANG_L  = 5'd0,
    OP_ANG_R  = 5'd1,
    OP_VEL_L  = 5'd2,
    OP_VEL_R  = 5'd3,
    OP_ERR_D  = 5'd4,
    OP_ERR_H  = 5'd5,
    OP_DER_D  = 5'd6,
    OP_DER_H  = 5'd7,
    OP_P_D    = 5'd8,
    OP_D_D    = 5'd9,
    OP_P_H    = 5'd10,
    OP_D_H    = 5'd11,
    OP_ERR_FR = 5'd12,
    OP_ERR_TR = 5'd13,
    OP_SIGMA  = 5'd14,
    OP_DELTA  = 5'd15,
    OP_PWM_R  = 5'd16,
    OP_PWM_L  = 5'd17
  } op_e;

  typedef enum logic [1:0] {
    PM_DIV_CPR,
    PM_DIV_DT,
    PM_SH16,
    PM_SH32
  } post_e;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/diff_drive_cascaded_pd_controller.sv -----
// One request at a time: in_stall_o holds off a new request until the current one is finished.
// The work is done on one shared 34x32 multiplier and a radix-2 divider, which serves each
// of the six divisions (angles and time derivatives).
// A finished result waits in the output register while the next request is processed.
// Reset (rst_ni low, asynchronous) restores the gains and targets and clears the stored
// wheel angles and loop errors.
`timescale 1ns / 1ps
`default_nettype none
module diff_drive_cascaded_pd_controller
  import ddcpd_pkg::*;
#(
  parameter int unsigned COUNTS_PER_REV = CountsPerRevDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] count_left_i,
  input  wire logic signed [31:0] count_right_i,
  input  wire logic [15:0]        elapsed_ms_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [6:0]              pwm_right_o,
  output logic [6:0]              pwm_left_o,
  output logic                    dir_first_o,
  output logic                    dir_second_o,
  output logic                    in_deadband_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic [15:0] CprVal = 16'(COUNTS_PER_REV);

  // Configuration registers.
  logic [30:0]        kp_d_q, kd_d_q, kp_h_q, kd_h_q, kp_fr_q, kp_tr_q;
  logic signed [31:0] tgt_d_q, tgt_h_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_d_q  <= KP_DIST_RST;
      kd_d_q  <= KD_DIST_RST;
      kp_h_q  <= KP_HEAD_RST;
      kd_h_q  <= KD_HEAD_RST;
      kp_fr_q <= KP_FR_RST;
      kp_tr_q <= KP_TR_RST;
      tgt_d_q <= TGT_DIST_RST;
      tgt_h_q <= TGT_HEAD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KP_DIST:  kp_d_q  <= pwdata[30:0];
        REG_KD_DIST:  kd_d_q  <= pwdata[30:0];
        REG_KP_HEAD:  kp_h_q  <= pwdata[30:0];
        REG_KD_HEAD:  kd_h_q  <= pwdata[30:0];
        REG_KP_FR:    kp_fr_q <= pwdata[30:0];
        REG_KP_TR:    kp_tr_q <= pwdata[30:0];
        REG_TGT_DIST: tgt_d_q <= pwdata;
        REG_TGT_HEAD: tgt_h_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KP_DIST:  prdata = {1'b0, kp_d_q};
      REG_KD_DIST:  prdata = {1'b0, kd_d_q};
      REG_KP_HEAD:  prdata = {1'b0, kp_h_q};
      REG_KD_HEAD:  prdata = {1'b0, kd_h_q};
      REG_KP_FR:    prdata = {1'b0, kp_fr_q};
      REG_KP_TR:    prdata = {1'b0, kp_tr_q};
      REG_TGT_DIST: prdata = tgt_d_q;
      REG_TGT_HEAD: prdata = tgt_h_q;
      default:      prdata = 32'd0;
    endcase
  end

  // Sequencer.
  state_e state_q, state_d;
  op_e    op_q;
  logic [DCNT_W-1:0] cnt_q;
  logic   out_valid_q;
  logic   in_acc;
  logic   ld_en, mul_en, dset_en, div_en, post_en, wb_en, fin_en;
  logic   last_bit;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign last_bit = (cnt_q == DCNT_W'(DIV_W - 1));

  post_e pm_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_MUL;
      ST_MUL:  state_d = (pm_q == PM_DIV_CPR || pm_q == PM_DIV_DT) ? ST_DSET : ST_POST;
      ST_DSET: state_d = ST_DIV;
      ST_DIV:  if (last_bit) state_d = ST_POST;
      ST_POST: state_d = ST_WB;
      ST_WB:   state_d = (op_q == OP_PWM_L) ? ST_DONE : ST_LOAD;
      ST_DONE: if (!(out_valid_q && out_stall_i)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ld_en   = (state_q == ST_LOAD);
    mul_en  = (state_q == ST_MUL);
    dset_en = (state_q == ST_DSET);
    div_en  = (state_q == ST_DIV);
    post_en = (state_q == ST_POST);
    wb_en   = (state_q == ST_WB);
    fin_en  = (state_q == ST_DONE) && !(out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_ANG_L;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        op_q <= OP_ANG_L;
      end else if (wb_en && op_q != OP_PWM_L) begin
        op_q <= op_e'(op_q + 5'd1);
      end
      if (fin_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Working registers.
  logic signed [31:0] cl_q, cr_q;
  logic [15:0]        dt_q;
  logic signed [31:0] al_q, ar_q, vl_q, vr_q, ed_q, eh_q, ded_q, deh_q;
  logic signed [31:0] tmp_q, wrho_q, wphi_q, erd_q, epd_q, sig_q, del_q;
  logic [7:0]         pr_q, pl_q;
  logic signed [31:0] pal_q, par_q, ped_q, peh_q;

  // Operand selection.
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  post_e                  pm;
  logic signed [MA_W-1:0] abs_ar, ext_al, ext_ar, ext_vl, ext_vr, sd_sum, sd_dif;

  assign ext_al = {{2{al_q[31]}}, al_q};
  assign ext_ar = {{2{ar_q[31]}}, ar_q};
  assign ext_vl = {{2{vl_q[31]}}, vl_q};
  assign ext_vr = {{2{vr_q[31]}}, vr_q};
  assign abs_ar = ar_q[31] ? -ext_ar : ext_ar;
  // Sum and difference halved with truncation toward zero.
  assign sd_sum = ({{2{sig_q[31]}}, sig_q} + {{2{del_q[31]}}, del_q});
  assign sd_dif = ({{2{sig_q[31]}}, sig_q} - {{2{del_q[31]}}, del_q});

  always_comb begin
    ma = '0;
    mb = '0;
    pm = PM_SH16;
    case (op_q)
      OP_ANG_L: begin
        ma = {{2{cl_q[31]}}, cl_q}; mb = TWO_PI_Q; pm = PM_DIV_CPR;
      end
      OP_ANG_R: begin
        ma = {{2{cr_q[31]}}, cr_q}; mb = TWO_PI_Q; pm = PM_DIV_CPR;
      end
      OP_VEL_L: begin
        ma = ext_al - {{2{pal_q[31]}}, pal_q}; mb = MS_PER_S; pm = PM_DIV_DT;
      end
      OP_VEL_R: begin
        ma = {{2{par_q[31]}}, par_q} - ext_ar; mb = MS_PER_S; pm = PM_DIV_DT;
      end
      OP_ERR_D: begin
        ma = abs_ar + ext_al; mb = K_RHO_Q;
      end
      OP_ERR_H: begin
        ma = abs_ar - ext_al; mb = K_PHI_Q;
      end
      OP_DER_D: begin
        ma = {{2{ed_q[31]}}, ed_q} - {{2{ped_q[31]}}, ped_q};
        mb = MS_PER_S; pm = PM_DIV_DT;
      end
      OP_DER_H: begin
        ma = {{2{eh_q[31]}}, eh_q} - {{2{peh_q[31]}}, peh_q};
        mb = MS_PER_S; pm = PM_DIV_DT;
      end
      OP_P_D:    begin ma = {3'b000, kp_d_q};  mb = ed_q;  end
      OP_D_D:    begin ma = {3'b000, kd_d_q};  mb = ded_q; end
      OP_P_H:    begin ma = {3'b000, kp_h_q};  mb = eh_q;  end
      OP_D_H:    begin ma = {3'b000, kd_h_q};  mb = deh_q; end
      OP_ERR_FR: begin ma = ext_vr + ext_vl;   mb = K_RHO_Q; end
      OP_ERR_TR: begin ma = ext_vr - ext_vl;   mb = K_PHI_Q; end
      OP_SIGMA:  begin ma = {3'b000, kp_fr_q}; mb = erd_q; end
      OP_DELTA:  begin ma = {3'b000, kp_tr_q}; mb = epd_q; end
      OP_PWM_R: begin
        ma = $signed(sd_sum + {{(MA_W-1){1'b0}}, sd_sum[MA_W-1]}) >>> 1;
        mb = PWM_PER_VOLT_Q; pm = PM_SH32;
      end
      OP_PWM_L: begin
        ma = $signed(sd_dif + {{(MA_W-1){1'b0}}, sd_dif[MA_W-1]}) >>> 1;
        mb = PWM_PER_VOLT_Q; pm = PM_SH32;
      end
      default: ;
    endcase
  end

  // Shared multiplier, divider and post scaling.
  logic signed [MA_W-1:0] ma_q;
  logic signed [MB_W-1:0] mb_q;
  logic signed [P_W-1:0]  p_q;
  logic [P_W-1:0]         p_mag;
  logic [DIV_W-1:0]       dvd_q;
  logic [15:0]            rem_q, dvs_q;
  logic                   neg_q;
  logic [16:0]            rem_sh;
  logic                   q_bit;
  logic signed [31:0]     res_q;
  logic [7:0]             pwmv_q;

  assign p_mag  = p_q[P_W-1] ? P_W'(-p_q) : P_W'(p_q);
  assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, dvs_q});

  logic signed [P_W-1:0] adj16, adj32, sh16, sh32;
  logic signed [DIV_W:0] quo_s;
  logic [7:0]            pwm_abs;

  assign adj16 = p_q + (p_q[P_W-1] ? P_W'(65535) : P_W'(0));
  assign adj32 = p_q + (p_q[P_W-1] ? P_W'(64'h0000_0000_FFFF_FFFF) : P_W'(0));
  assign sh16  = adj16 >>> 16;
  assign sh32  = adj32 >>> 32;
  assign quo_s = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

  always_comb begin
    if (sh32 > $signed(P_W'(255)) || sh32 < -$signed(P_W'(255))) begin
      pwm_abs = PWM_LIMIT;
    end else if (sh32[P_W-1]) begin
      pwm_abs = 8'(-sh32[8:0]);
    end else begin
      pwm_abs = sh32[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_en) begin
      ma_q <= ma;
      mb_q <= mb;
      pm_q <= pm;
    end
    if (mul_en) begin
      p_q <= ma_q * mb_q;
    end
    if (dset_en) begin
      dvd_q <= p_mag[DIV_W-1:0];
      neg_q <= p_q[P_W-1];
      rem_q <= '0;
      cnt_q <= '0;
      dvs_q <= (pm_q == PM_DIV_CPR) ? CprVal : dt_q;
    end
    if (div_en) begin
      rem_q <= q_bit ? 16'(rem_sh - {1'b0, dvs_q}) : rem_sh[15:0];
      dvd_q <= {dvd_q[DIV_W-2:0], q_bit};
      cnt_q <= cnt_q + DCNT_W'(1);
    end
    if (post_en) begin
      case (pm_q)
        PM_DIV_CPR, PM_DIV_DT: res_q <= sat32(68'(quo_s));
        PM_SH16:               res_q <= sat32(68'(sh16));
        PM_SH32:               pwmv_q <= pwm_abs;
        default: ;
      endcase
    end
  end

  // Write back and stored loop state.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cl_q <= count_left_i;
      cr_q <= count_right_i;
      dt_q <= (elapsed_ms_i == 16'd0) ? 16'd1 : elapsed_ms_i;
    end
    if (wb_en) begin
      case (op_q)
        OP_ANG_L:  al_q  <= res_q;
        OP_ANG_R:  ar_q  <= res_q;
        OP_VEL_L:  vl_q  <= res_q;
        OP_VEL_R:  vr_q  <= res_q;
        OP_ERR_D:  ed_q  <= sat32(68'(tgt_d_q) - 68'(res_q));
        OP_ERR_H:  eh_q  <= sat32(68'(tgt_h_q) - 68'(res_q));
        OP_DER_D:  ded_q <= res_q;
        OP_DER_H:  deh_q <= res_q;
        OP_P_D:    tmp_q <= res_q;
        OP_D_D:    wrho_q <= sat32(68'(tmp_q) + 68'(res_q));
        OP_P_H:    tmp_q <= res_q;
        OP_D_H:    wphi_q <= sat32(68'(tmp_q) + 68'(res_q));
        OP_ERR_FR: erd_q <= sat32(68'(wrho_q) - 68'(res_q));
        OP_ERR_TR: epd_q <= sat32(68'(wphi_q) - 68'(res_q));
        OP_SIGMA:  sig_q <= res_q;
        OP_DELTA:  del_q <= res_q;
        OP_PWM_R:  pr_q  <= pwmv_q;
        OP_PWM_L:  pl_q  <= pwmv_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q <= '0;
      par_q <= '0;
      ped_q <= '0;
      peh_q <= '0;
    end else if (fin_en) begin
      pal_q <= al_q;
      par_q <= ar_q;
      ped_q <= ed_q;
      peh_q <= eh_q;
    end
  end

  // Output register.
  logic [6:0] pwm_r_q, pwm_l_q;
  logic       dir1_q, dir2_q, db_q;
  logic       dead;

  assign dead = (eh_q > -DEADBAND_Q) && (eh_q < DEADBAND_Q);

  always_ff @(posedge clk_i) begin
    if (fin_en) begin
      if (dead) begin
        pwm_r_q <= '0;
        pwm_l_q <= '0;
        dir1_q  <= 1'b1;
        dir2_q  <= 1'b0;
        db_q    <= 1'b1;
      end else if (!eh_q[31]) begin
        pwm_r_q <= pr_q[7:1];
        pwm_l_q <= pl_q[7:1];
        dir1_q  <= 1'b1;
        dir2_q  <= 1'b0;
        db_q    <= 1'b0;
      end else begin
        pwm_r_q <= PWM_FIXED;
        pwm_l_q <= PWM_FIXED;
        dir1_q  <= 1'b0;
        dir2_q  <= 1'b1;
        db_q    <= 1'b0;
      end
    end
  end

  assign pwm_right_o   = pwm_r_q;
  assign pwm_left_o    = pwm_l_q;
  assign dir_first_o   = dir1_q;
  assign dir_second_o  = dir2_q;
  assign in_deadband_o = db_q;

  // A finished request never replaces a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_en |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  // A new request always starts the sequence at the first wheel angle.
  a_start_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_LOAD && op_q == OP_ANG_L))
    else $error("sequence did not restart");

  // The divider finishes within its bit count.
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && last_bit) |=> (state_q == ST_POST))
    else $error("divider overran");

  // A stopped drive shows zero duty on both motors and forward pins.
  a_deadband: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_deadband_o) |->
      (pwm_right_o == 7'd0 && pwm_left_o == 7'd0 && dir_first_o && !dir_second_o))
    else $error("deadband output inconsistent");

endmodule
`default_nettype wire
